/* hdl/u8e_pkg.sv */
package u8e_pkg;

	localparam logic [7:0] QMARK = 8'h3F;
	localparam logic [15:0] SHIFT_OFFSET = 16'hE000;
	localparam logic [7:0] LOW_ADJUST = 8'd14;
	localparam logic [7:0] HIGH_ADJUST = 8'd9;
	localparam logic [7:0] ESCAPE_BASE_RESET = 8'd16;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [20:0] SURR_LO = 21'h00D800;
	localparam logic [20:0] SURR_HI = 21'h00DFFF;
	localparam logic [15:0] SHIFT_LO = 16'h0100;
	localparam logic [15:0] SHIFT_HI = 16'h0A00;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_TRUNC     = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] o0;
		logic [7:0] o1;
		logic [7:0] o2;
		logic [7:0] o3;
		logic [2:0] count;
		logic [2:0] consumed;
		status_t    status;
	} res_t;

	// bytes that may not appear raw in an escape pair
	function automatic logic reserved_byte(input logic [7:0] b);
		logic r;
		r = 1'b0;
		unique case (b)
			8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20,
			8'h0D, 8'h0A, 8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E,
			8'h2F, 8'h5F, 8'hBD, 8'h3B, 8'h5D, 8'h3D, 8'h23, 8'h3F,
			8'h3A, 8'h3C, 8'h3E, 8'h2A, 8'h7C: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Windows-1252 specials; zero means no mapping
	function automatic logic [7:0] cp1252_special(input logic [15:0] cp);
		logic [7:0] r;
		r = 8'h00;
		unique case (cp)
			16'h20AC: r = 8'h80;
			16'h201A: r = 8'h82;
			16'h0192: r = 8'h83;
			16'h201E: r = 8'h84;
			16'h2026: r = 8'h85;
			16'h2020: r = 8'h86;
			16'h2021: r = 8'h87;
			16'h02C6: r = 8'h88;
			16'h2030: r = 8'h89;
			16'h0160: r = 8'h8A;
			16'h2039: r = 8'h8B;
			16'h0152: r = 8'h8C;
			16'h017D: r = 8'h8E;
			16'h2018: r = 8'h91;
			16'h2019: r = 8'h92;
			16'h201C: r = 8'h93;
			16'h201D: r = 8'h94;
			16'h2022: r = 8'h95;
			16'h2013: r = 8'h96;
			16'h2014: r = 8'h97;
			16'h02DC: r = 8'h98;
			16'h2122: r = 8'h99;
			16'h0161: r = 8'h9A;
			16'h203A: r = 8'h9B;
			16'h0153: r = 8'h9C;
			16'h017E: r = 8'h9E;
			16'h0178: r = 8'h9F;
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* hdl/utf8_to_escaped_encoder_unit.sv */
// UTF-8 to escaped single-byte encoder, one code point per item.
//
// Input channel: byte0..byte3 hold the window at the current position and
// avail the bytes left there (capped at four). An item is taken when
// in_valid is high and in_stall is low. Output channel: out0..out3,
// out_count, consumed and status, taken when out_valid is high and
// out_stall is low. The host advances its position by consumed.
//
// The path is an input register, the decode/encode logic, then the result register.
// Throughput is one item per cycle unless out_stall holds the flow; the rate is
// set by the single pass through the codec between those two registers.
// When the receiver stalls, the result register holds and the input
// register fills; in_stall rises only when both are occupied.
//
// Reset empties both stages and sets escape_base to 16. The user must write
// escape_base through cfg_wr_en/cfg_wr_data only while the block is idle; unguarded.
module utf8_to_escaped_encoder_unit
	import u8e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	input  logic [7:0] byte3,
	input  logic [2:0] avail,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out0,
	output logic [7:0] out1,
	output logic [7:0] out2,
	output logic [7:0] out3,
	output logic [2:0] out_count,
	output logic [2:0] consumed,
	output logic [1:0] status
);

	logic [7:0] escape_base_q;
	logic       vld_s1;
	logic       vld_s2;
	logic [7:0] b0_s1;
	logic [7:0] b1_s1;
	logic [7:0] b2_s1;
	logic [7:0] b3_s1;
	logic [2:0] avail_s1;
	res_t       res;
	res_t       res_s2;
	logic       adv_s1;
	logic       adv_s2;

	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_base_q <= ESCAPE_BASE_RESET;
		end else if (cfg_wr_en) begin
			escape_base_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			b0_s1    <= byte0;
			b1_s1    <= byte1;
			b2_s1    <= byte2;
			b3_s1    <= byte3;
			avail_s1 <= avail;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res;
		end
	end

	u8e_codec u_codec (
		.b0          (b0_s1),
		.b1          (b1_s1),
		.b2          (b2_s1),
		.b3          (b3_s1),
		.avail       (avail_s1),
		.escape_base (escape_base_q),
		.res         (res)
	);

	assign out_valid = vld_s2;
	assign out0      = res_s2.o0;
	assign out1      = res_s2.o1;
	assign out2      = res_s2.o2;
	assign out3      = res_s2.o3;
	assign out_count = res_s2.count;
	assign consumed  = res_s2.consumed;
	assign status    = res_s2.status;

endmodule

/* hdl/u8e_codec.sv */
module u8e_codec
	import u8e_pkg::*;
(
	input  logic [7:0] b0,
	input  logic [7:0] b1,
	input  logic [7:0] b2,
	input  logic [7:0] b3,
	input  logic [2:0] avail,
	input  logic [7:0] escape_base,
	output res_t       res
);

	logic [2:0]  avail_n;
	logic [2:0]  expected;
	logic        bad;
	logic [20:0] v;
	logic [20:0] cp;
	logic [2:0]  cons;
	status_t     st;
	logic [7:0]  spec;
	logic [15:0] c;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        lo_res;
	logic        hi_res;
	logic        c1_range;

	always_comb begin
		priority if (avail == 3'd0) begin
			avail_n = 3'd1;
		end else if (avail > 3'd4) begin
			avail_n = 3'd4;
		end else begin
			avail_n = avail;
		end
	end

	always_comb begin
		priority if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
			expected = 3'd2;
		end else if (b0 >= 8'hE0 && b0 <= 8'hEF) begin
			expected = 3'd3;
		end else if (b0 >= 8'hF0 && b0 <= 8'hF4) begin
			expected = 3'd4;
		end else begin
			expected = 3'd0;
		end
	end

	always_comb begin
		bad = 1'b0;
		v = '0;
		unique case (expected)
			3'd2: begin
				bad = (b1[7:6] != 2'b10);
				v = {10'd0, b0[4:0], b1[5:0]};
			end
			3'd3: begin
				bad = (b1[7:6] != 2'b10) || (b2[7:6] != 2'b10);
				v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			end
			3'd4: begin
				bad = (b1[7:6] != 2'b10) || (b2[7:6] != 2'b10) || (b3[7:6] != 2'b10);
				v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			end
			default: begin
				bad = 1'b0;
				v = '0;
			end
		endcase
		if (!bad) begin
			// overlong, surrogate and out-of-range forms
			if ((expected == 3'd3 && v < 21'h000800) ||
			    (expected == 3'd4 && v < 21'h010000) ||
			    (v >= SURR_LO && v <= SURR_HI) || v > CP_MAX) begin
				bad = 1'b1;
			end
		end
	end

	always_comb begin
		cp = {13'd0, QMARK};
		cons = 3'd1;
		st = ST_OK;
		priority if (!b0[7]) begin
			cp = {13'd0, b0};
		end else if (expected == 3'd0) begin
			st = ST_MALFORMED;
		end else if (avail_n < expected) begin
			st = ST_TRUNC;
		end else if (bad) begin
			st = ST_MALFORMED;
		end else begin
			cp = v;
			cons = expected;
		end
	end

	assign spec     = cp1252_special(cp[15:0]);
	assign c1_range = (cp >= 21'h80 && cp <= 21'h9F);
	assign c        = (cp[15:0] > SHIFT_LO && cp[15:0] < SHIFT_HI) ?
	                  cp[15:0] + SHIFT_OFFSET : cp[15:0];
	assign lo_res   = reserved_byte(c[7:0]);
	assign hi_res   = reserved_byte(c[15:8]);

	always_comb begin
		lo = lo_res ? c[7:0] + LOW_ADJUST : c[7:0];
		hi = hi_res ? c[15:8] - HIGH_ADJUST : c[15:8];
	end

	always_comb begin
		res.o0 = 8'h00;
		res.o1 = 8'h00;
		res.o2 = 8'h00;
		res.o3 = 8'h00;
		res.count = 3'd1;
		res.consumed = cons;
		res.status = st;
		priority if (cons == 3'd4) begin
			res.o0 = QMARK;
			res.o1 = QMARK;
			res.o2 = QMARK;
			res.o3 = QMARK;
			res.count = 3'd4;
		end else if (cp <= 21'hFF && !c1_range) begin
			res.o0 = cp[7:0];
		end else if (spec != 8'h00) begin
			res.o0 = spec;
		end else if (c[15:8] == 8'h00) begin
			// C1 control emitted raw
			res.o0 = c[7:0];
		end else begin
			res.o0 = escape_base + {6'd0, hi_res, lo_res};
			res.o1 = lo;
			res.o2 = hi;
			res.count = 3'd3;
		end
	end

endmodule

/* hdl/u8e_checker.sv */
module u8e_checker
	import u8e_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out0,
	input logic [7:0] out1,
	input logic [7:0] out2,
	input logic [7:0] out3,
	input logic [2:0] out_count,
	input logic [2:0] consumed,
	input logic [1:0] status
);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out0) && $stable(out1) &&
		$stable(out2) && $stable(out3) && $stable(out_count) && $stable(consumed) &&
		$stable(status))
		else $error("stalled item changed");

	a_four: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed == 3'd4 |-> out_count == 3'd4 &&
		status == ST_OK && out0 == QMARK && out3 == QMARK)
		else $error("four-byte sequence not four question marks");

	// any error consumes one byte and yields a single '?'
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> consumed == 3'd1 && out_count == 3'd1 &&
		out0 == QMARK)
		else $error("error item malformed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count == 3'd1 || out_count == 3'd3 || out_count == 3'd4) &&
		(out_count == 3'd4 || out3 == 8'h00) && (out_count != 3'd1 || out1 == 8'h00))
		else $error("bad output count or unused byte not zero");

endmodule

bind utf8_to_escaped_encoder_unit u8e_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out0      (out0),
	.out1      (out1),
	.out2      (out2),
	.out3      (out3),
	.out_count (out_count),
	.consumed  (consumed),
	.status    (status)
);
